// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- hdl/tvsc_pkg.sv -----
`default_nettype none
package tvsc_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int SP_W = $clog2(STACK_DEPTH);

    localparam logic [2:0] ROLE_TAG = 3'd0;
    localparam logic [2:0] ROLE_LEN = 3'd1;
    localparam logic [2:0] ROLE_INT = 3'd2;
    localparam logic [2:0] ROLE_STR = 3'd3;
    localparam logic [2:0] ROLE_RAW = 3'd4;
    localparam logic [2:0] ROLE_IGN = 3'd5;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_TAG   = 3'd1;
    localparam logic [2:0] ST_TRUNC = 3'd2;
    localparam logic [2:0] ST_DEEP  = 3'd3;
    localparam logic [2:0] ST_NODES = 3'd4;
    localparam logic [2:0] ST_UTF8  = 3'd5;
    localparam logic [2:0] ST_TRAIL = 3'd6;

    localparam logic [7:0] TAG_TRUE = 8'd2;
    localparam logic [7:0] TAG_INT  = 8'd3;
    localparam logic [7:0] TAG_STR  = 8'd4;
    localparam logic [7:0] TAG_RAW  = 8'd5;
    localparam logic [7:0] TAG_LIST = 8'd6;

    localparam logic [1:0] CFG_MAX_NODES = 2'd0;
    localparam logic [1:0] CFG_MAX_DEPTH = 2'd1;

    typedef enum logic [4:0] {
        PH_TAG  = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_INT  = 5'b00100,
        PH_PAY  = 5'b01000,
        PH_DONE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] byte_role;
        logic [7:0] value_tag;
        logic [6:0] nest_depth;
        logic       value_done;
        logic [2:0] status;
        logic       end_of_buffer;
    } out_beat_t;

    // controller -> datapath
    typedef struct packed {
        logic take;     // latch input beat, run parse step
        logic pop;      // one pop-loop step over the stack
        logic emit;     // load output register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic closing;  // pop loop still running
    } dp_sts_t;
endpackage
`default_nettype wire

// ----- hdl/tagged_value_stream_checker_core.sv -----
`default_nettype none
// Streaming checker for one tagged, length-prefixed value, one byte per beat.
// Each accepted beat yields exactly one result beat: the byte's role, the tag
// and nesting depth of its value, a top-level done flag and a sticky status
// (final at the beat marked last_byte, after which the parser clears for the
// next value). A beat passes through accept, closing check and result load, in
// that order. A byte that completes an element adds one stack step for the
// element and one more for every list that it closes, since the list-count
// stack is a memory with one write and one read port, stepped once per cycle.
// A result still held by a stalled receiver delays the result load and so the
// next accept. The user must write config (cfg_we/cfg_index/cfg_data) only
// while idle; the block does not enforce this. Indexes above 1 are ignored.
`include "assert_macros.svh"
module tagged_value_stream_checker_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_data,
    input  wire                 in_valid,
    output logic                in_stall,
    input  tvsc_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output tvsc_pkg::out_beat_t out_data
);
    import tvsc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // controller sequences accept, list closing and result hand-off
    tvsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: parser state, UTF-8 checker, count stack, result register
    tvsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_beat  (out_data)
    );

    // an accepted beat is never taken while another is in flight
    `ASSERT_NEXT(a_no_take_twice, clk, rst_n, cmd.take, !cmd.take)
    // result load only when the output register is free or draining
    `ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.emit, !out_valid || !out_stall)
    // an ignored byte carries no tag
    `ASSERT_IMPLIES(a_ign_tag, clk, rst_n,
        out_valid && out_data.byte_role == ROLE_IGN, out_data.value_tag == 8'd0)
endmodule
`default_nettype wire

// ----- hdl/tvsc_ctrl.sv -----
`default_nettype none
module tvsc_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire               out_stall,
    input  tvsc_pkg::dp_sts_t sts,
    output tvsc_pkg::dp_cmd_t cmd
);
    import tvsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg;
        cmd = '0;
        in_stall = 1'b1;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sts.closing)
                    cmd.pop = 1'b1;
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ov_next)
                begin
                    cmd.emit = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// ----- hdl/tvsc_datapath.sv -----
`default_nettype none
module tvsc_datapath (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_data,
    input  tvsc_pkg::in_beat_t  in_beat,
    input  tvsc_pkg::dp_cmd_t   cmd,
    output tvsc_pkg::dp_sts_t   sts,
    output tvsc_pkg::out_beat_t out_beat
);
    import tvsc_pkg::*;

    logic [31:0] max_nodes_reg;
    logic [6:0]  max_depth_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] pay_reg, pay_next;
    logic [6:0]  lvl_reg, lvl_next;
    logic [31:0] nodes_reg, nodes_next;
    logic [1:0]  upend_reg, upend_next;
    logic [7:0]  ulo_reg, ulo_next, uhi_reg, uhi_next;
    logic        ubad_reg, ubad_next;
    logic [2:0]  err_reg, err_next;
    logic        top_reg, top_next;
    logic [7:0]  tag_reg, tag_next;
    logic        close_reg, close_next;
    logic        last_reg;
    out_beat_t   res_reg, res_next;
    out_beat_t   obuf_reg;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] stk_rd;
    logic        push;
    logic [SP_W-1:0] push_idx, top_idx;
    logic [31:0] push_val;

    // pop loop: stk_rd holds the entry at lvl-1 (read on entry, each pop step)
    logic [SP_W-1:0] rd_idx;
    logic [6:0]      rd_lvl;
    logic            pop_wr;

    always_comb
    begin
        logic [7:0] b;
        logic [31:0] acc;
        b = in_beat.data_byte;
        phase_next = phase_reg; fcnt_next = fcnt_reg; acc_next = acc_reg;
        pay_next = pay_reg; lvl_next = lvl_reg; nodes_next = nodes_reg;
        upend_next = upend_reg; ulo_next = ulo_reg; uhi_next = uhi_reg;
        ubad_next = ubad_reg; err_next = err_reg; top_next = top_reg;
        tag_next = tag_reg; close_next = close_reg; res_next = res_reg;
        push = 1'b0; push_val = acc_reg; pop_wr = 1'b0;
        acc = acc_reg;
        if (cmd.take)
        begin
            res_next = '0;
            res_next.byte_role = ROLE_IGN;
            res_next.end_of_buffer = in_beat.last_byte;
            close_next = 1'b0;
            if (err_reg == ST_OK)
            begin
                if (top_reg)
                    err_next = ST_TRAIL;
                else if (phase_reg == PH_TAG)
                begin
                    res_next.byte_role = ROLE_TAG;
                    res_next.value_tag = b;
                    res_next.nest_depth = lvl_reg;
                    nodes_next = (lvl_reg == 7'd0) ? max_nodes_reg : nodes_reg;
                    if (nodes_next == 32'd0)
                        err_next = ST_NODES;
                    else
                    begin
                        nodes_next = nodes_next - 32'd1;
                        tag_next = b;
                        fcnt_next = 3'd0;
                        acc_next = '0;
                        if (b <= TAG_TRUE)
                            close_next = 1'b1;
                        else if (b == TAG_INT)
                            phase_next = PH_INT;
                        else if (b == TAG_STR || b == TAG_RAW)
                            phase_next = PH_LEN;
                        else if (b == TAG_LIST)
                        begin
                            if (lvl_reg >= max_depth_reg || lvl_reg >= 7'(STACK_DEPTH))
                                err_next = ST_DEEP;
                            else
                                phase_next = PH_LEN;
                        end
                        else
                            err_next = ST_TAG;
                    end
                end
                else if (phase_reg == PH_LEN)
                begin
                    res_next.byte_role = ROLE_LEN;
                    res_next.value_tag = tag_reg;
                    res_next.nest_depth = lvl_reg;
                    acc = acc_reg | (32'(b) << {fcnt_reg[1:0], 3'b000});
                    acc_next = acc;
                    fcnt_next = fcnt_reg + 3'd1;
                    if (fcnt_reg == 3'd3)
                    begin
                        fcnt_next = 3'd0;
                        if (tag_reg == TAG_LIST)
                        begin
                            if (acc > nodes_reg)
                                err_next = ST_NODES;
                            else if (acc == 32'd0)
                                close_next = 1'b1;
                            else
                            begin
                                push = 1'b1;
                                push_val = acc;
                                lvl_next = lvl_reg + 7'd1;
                                phase_next = PH_TAG;
                            end
                        end
                        else
                        begin
                            pay_next = acc;
                            upend_next = 2'd0; ulo_next = 8'h80; uhi_next = 8'hBF;
                            ubad_next = 1'b0;
                            if (acc == 32'd0)
                                close_next = 1'b1;
                            else
                                phase_next = PH_PAY;
                        end
                    end
                end
                else if (phase_reg == PH_INT)
                begin
                    res_next.byte_role = ROLE_INT;
                    res_next.value_tag = tag_reg;
                    res_next.nest_depth = lvl_reg;
                    fcnt_next = fcnt_reg + 3'd1;
                    if (fcnt_reg == 3'd7)
                    begin
                        fcnt_next = 3'd0;
                        close_next = 1'b1;
                    end
                end
                else if (phase_reg == PH_PAY)
                begin
                    res_next.byte_role = (tag_reg == TAG_STR) ? ROLE_STR : ROLE_RAW;
                    res_next.value_tag = tag_reg;
                    res_next.nest_depth = lvl_reg;
                    if (tag_reg == TAG_STR && !ubad_reg)
                    begin
                        if (upend_reg != 2'd0)
                        begin
                            if (b < ulo_reg || b > uhi_reg)
                                ubad_next = 1'b1;
                            else
                            begin
                                upend_next = upend_reg - 2'd1;
                                ulo_next = 8'h80; uhi_next = 8'hBF;
                            end
                        end
                        else
                        begin
                            ulo_next = 8'h80; uhi_next = 8'hBF;
                            if (b <= 8'h7F)
                                upend_next = 2'd0;
                            else if (b >= 8'hC2 && b <= 8'hDF)
                                upend_next = 2'd1;
                            else if (b == 8'hE0)
                            begin
                                upend_next = 2'd2; ulo_next = 8'hA0;
                            end
                            else if (b == 8'hED)
                            begin
                                upend_next = 2'd2; uhi_next = 8'h9F;
                            end
                            else if (b >= 8'hE1 && b <= 8'hEF)
                                upend_next = 2'd2;
                            else if (b == 8'hF0)
                            begin
                                upend_next = 2'd3; ulo_next = 8'h90;
                            end
                            else if (b >= 8'hF1 && b <= 8'hF3)
                                upend_next = 2'd3;
                            else if (b == 8'hF4)
                            begin
                                upend_next = 2'd3; uhi_next = 8'h8F;
                            end
                            else
                                ubad_next = 1'b1;
                        end
                    end
                    pay_next = pay_reg - 32'd1;
                    if (pay_reg == 32'd1)
                    begin
                        if (tag_reg == TAG_STR && (ubad_next || upend_next != 2'd0))
                            err_next = ST_UTF8;
                        else
                            close_next = 1'b1;
                    end
                end
                else
                    err_next = ST_TRAIL;
            end
            if (close_next)
                phase_next = PH_TAG;
        end
        else if (cmd.pop)
        begin
            // one step of closing lists: decrement top count, or at level 0 mark the value done
            if (lvl_reg == 7'd0)
            begin
                top_next = 1'b1;
                phase_next = PH_DONE;
                res_next.value_done = 1'b1;
                close_next = 1'b0;
            end
            else
            begin
                pop_wr = 1'b1;
                if (stk_rd != 32'd1)
                    close_next = 1'b0;
                else
                    lvl_next = lvl_reg - 7'd1;
            end
        end
        else if (cmd.emit)
        begin
            if (last_reg && err_reg == ST_OK && !top_reg)
                res_next.status = ST_TRUNC;
            else
                res_next.status = err_reg;
        end
    end

    assign top_idx  = (lvl_reg == 7'd0) ? '0 : SP_W'(lvl_reg - 7'd1);
    assign push_idx = SP_W'(lvl_reg);
    assign rd_lvl   = (cmd.take) ? lvl_next : lvl_next;
    assign rd_idx   = (rd_lvl == 7'd0) ? '0 : SP_W'(rd_lvl - 7'd1);

    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[push_idx] <= push_val;
        else if (pop_wr)
            stack_mem[top_idx] <= stk_rd - 32'd1;
        stk_rd <= (push) ? push_val : stack_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_nodes_reg <= 32'd65536;
            max_depth_reg <= 7'd64;
            phase_reg <= PH_TAG; fcnt_reg <= '0; acc_reg <= '0; pay_reg <= '0;
            lvl_reg <= '0; nodes_reg <= 32'd65536; upend_reg <= '0;
            ulo_reg <= 8'h80; uhi_reg <= 8'hBF; ubad_reg <= 1'b0;
            err_reg <= ST_OK; top_reg <= 1'b0; tag_reg <= '0;
            close_reg <= 1'b0; last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_NODES: max_nodes_reg <= cfg_data;
                    CFG_MAX_DEPTH: max_depth_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (cmd.take)
                last_reg <= in_beat.last_byte;
            if (cmd.emit && last_reg)
            begin
                phase_reg <= PH_TAG; fcnt_reg <= '0; acc_reg <= '0; pay_reg <= '0;
                lvl_reg <= '0; nodes_reg <= max_nodes_reg; upend_reg <= '0;
                ulo_reg <= 8'h80; uhi_reg <= 8'hBF; ubad_reg <= 1'b0;
                err_reg <= ST_OK; top_reg <= 1'b0; tag_reg <= '0;
                close_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next; fcnt_reg <= fcnt_next; acc_reg <= acc_next;
                pay_reg <= pay_next; lvl_reg <= lvl_next; nodes_reg <= nodes_next;
                upend_reg <= upend_next; ulo_reg <= ulo_next; uhi_reg <= uhi_next;
                ubad_reg <= ubad_next; err_reg <= err_next; top_reg <= top_next;
                tag_reg <= tag_next; close_reg <= close_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.emit)
        begin
            obuf_reg <= res_next;
        end
    end

    assign sts.closing = close_reg;
    assign out_beat = obuf_reg;
endmodule
`default_nettype wire

// ----- bench/tb_tagged_value_stream_checker_core.sv -----
`timescale 1ns / 1ps
module tb_tagged_value_stream_checker_core;
    import tvsc_pkg::*;

    // tags without a name in the package
    localparam logic [7:0] TAG_NULL  = 8'd0;
    localparam logic [7:0] TAG_FALSE = 8'd1;
    // register indexes that the block ignores
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int LONG_HOLD = 3000;
    localparam int DRAIN_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_beat_t   out_data;

    tagged_value_stream_checker_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Parser mirror: registers, stream state and the UTF-8 tracker
    // ---------------------------------------------------------------
    logic [31:0] m_max_nodes;
    logic [6:0]  m_max_depth;
    phase_t      m_phase;
    int unsigned m_fcnt;
    logic [31:0] m_len;
    logic [31:0] m_pay_left;
    logic [31:0] m_stack [0:STACK_DEPTH-1];
    int unsigned m_level;
    logic [31:0] m_nodes_left;
    int unsigned m_u8_pend;
    logic [7:0]  m_u8_lo;
    logic [7:0]  m_u8_hi;
    logic [2:0]  m_err;
    logic        m_top_done;
    logic [7:0]  m_cur_tag;
    logic        m_u8_bad;

    out_beat_t   result_q[$];     // beats still owed by the block
    logic [7:0]  enc_q[$];        // encoded buffer being assembled
    int          n_errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_cnt;
    int          quiet_cycles;
    int          bytes_sent;

    function automatic void clear_stream();
        m_phase = PH_TAG;
        m_fcnt = 0;
        m_len = '0;
        m_pay_left = '0;
        for (int i = 0; i < STACK_DEPTH; i++)
            m_stack[i] = '0;
        m_level = 0;
        m_nodes_left = m_max_nodes;
        m_u8_pend = 0;
        m_u8_lo = 8'h80;
        m_u8_hi = 8'hBF;
        m_err = ST_OK;
        m_top_done = 1'b0;
        m_cur_tag = '0;
        m_u8_bad = 1'b0;
    endfunction

    function automatic void utf8_track(logic [7:0] b);
        if (m_u8_bad)
            return;
        if (m_u8_pend != 0)
        begin
            if (b < m_u8_lo || b > m_u8_hi)
            begin
                m_u8_bad = 1'b1;
                return;
            end
            m_u8_pend--;
            m_u8_lo = 8'h80;
            m_u8_hi = 8'hBF;
            return;
        end
        m_u8_lo = 8'h80;
        m_u8_hi = 8'hBF;
        if (b <= 8'h7F)
            return;
        if (b >= 8'hC2 && b <= 8'hDF)
            m_u8_pend = 1;
        else if (b == 8'hE0)
        begin
            m_u8_pend = 2;
            m_u8_lo = 8'hA0;
        end
        else if (b == 8'hED)
        begin
            m_u8_pend = 2;
            m_u8_hi = 8'h9F;
        end
        else if (b >= 8'hE1 && b <= 8'hEF)
            m_u8_pend = 2;
        else if (b == 8'hF0)
        begin
            m_u8_pend = 3;
            m_u8_lo = 8'h90;
        end
        else if (b >= 8'hF1 && b <= 8'hF3)
            m_u8_pend = 3;
        else if (b == 8'hF4)
        begin
            m_u8_pend = 3;
            m_u8_hi = 8'h8F;
        end
        else
            m_u8_bad = 1'b1;
    endfunction

    // an element finished: pop every list it closes; 1 when the root is done
    function automatic bit close_element();
        int unsigned idx;
        m_phase = PH_TAG;
        forever
        begin
            if (m_level == 0)
            begin
                m_top_done = 1'b1;
                m_phase = PH_DONE;
                return 1'b1;
            end
            idx = m_level - 1;
            if (idx >= STACK_DEPTH)
                idx = STACK_DEPTH - 1;
            m_stack[idx] = m_stack[idx] - 1;
            if (m_stack[idx] != 0)
                return 1'b0;
            m_level--;
        end
    endfunction

    function automatic out_beat_t decode_byte(in_beat_t ib);
        out_beat_t r;
        logic [7:0] b;
        b = ib.data_byte;
        r = '0;
        r.byte_role = ROLE_IGN;
        if (m_err == ST_OK)
        begin
            if (m_top_done)
                m_err = ST_TRAIL;
            else
            begin
                case (m_phase)
                    PH_TAG:
                    begin
                        r.byte_role = ROLE_TAG;
                        r.value_tag = b;
                        r.nest_depth = m_level[6:0];
                        if (m_level == 0)
                            m_nodes_left = m_max_nodes;
                        if (m_nodes_left == 0)
                            m_err = ST_NODES;
                        else
                        begin
                            m_nodes_left--;
                            m_cur_tag = b;
                            m_fcnt = 0;
                            m_len = '0;
                            if (b <= TAG_TRUE)
                                r.value_done = close_element();
                            else if (b == TAG_INT)
                                m_phase = PH_INT;
                            else if (b == TAG_STR || b == TAG_RAW)
                                m_phase = PH_LEN;
                            else if (b == TAG_LIST)
                            begin
                                if (m_level >= m_max_depth || m_level >= STACK_DEPTH)
                                    m_err = ST_DEEP;
                                else
                                    m_phase = PH_LEN;
                            end
                            else
                                m_err = ST_TAG;
                        end
                    end
                    PH_LEN:
                    begin
                        r.byte_role = ROLE_LEN;
                        r.value_tag = m_cur_tag;
                        r.nest_depth = m_level[6:0];
                        m_len = m_len | ({24'd0, b} << (8 * (m_fcnt & 3)));
                        m_fcnt++;
                        if (m_fcnt >= 4)
                        begin
                            m_fcnt = 0;
                            if (m_cur_tag == TAG_LIST)
                            begin
                                if (m_len > m_nodes_left)
                                    m_err = ST_NODES;
                                else if (m_len == 0)
                                    r.value_done = close_element();
                                else
                                begin
                                    m_stack[m_level] = m_len;
                                    m_level++;
                                    m_phase = PH_TAG;
                                end
                            end
                            else
                            begin
                                m_pay_left = m_len;
                                m_u8_pend = 0;
                                m_u8_lo = 8'h80;
                                m_u8_hi = 8'hBF;
                                m_u8_bad = 1'b0;
                                if (m_pay_left == 0)
                                    r.value_done = close_element();
                                else
                                    m_phase = PH_PAY;
                            end
                        end
                    end
                    PH_INT:
                    begin
                        r.byte_role = ROLE_INT;
                        r.value_tag = m_cur_tag;
                        r.nest_depth = m_level[6:0];
                        m_fcnt++;
                        if (m_fcnt >= 8)
                        begin
                            m_fcnt = 0;
                            r.value_done = close_element();
                        end
                    end
                    PH_PAY:
                    begin
                        r.byte_role = (m_cur_tag == TAG_STR) ? ROLE_STR : ROLE_RAW;
                        r.value_tag = m_cur_tag;
                        r.nest_depth = m_level[6:0];
                        if (m_cur_tag == TAG_STR)
                            utf8_track(b);
                        m_pay_left--;
                        if (m_pay_left == 0)
                        begin
                            if (m_cur_tag == TAG_STR && (m_u8_bad || m_u8_pend != 0))
                                m_err = ST_UTF8;
                            else
                                r.value_done = close_element();
                        end
                    end
                    default:
                        m_err = ST_TRAIL;
                endcase
            end
        end
        if (ib.last_byte && m_err == ST_OK && !m_top_done)
            m_err = ST_TRUNC;
        r.status = m_err;
        r.end_of_buffer = ib.last_byte;
        if (ib.last_byte)
            clear_stream();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Monitors: input beats feed the mirror, output beats are checked
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            result_q.insert(result_q.size(), decode_byte(in_data));
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, out_data);
                n_errors++;
            end
            else
            begin
                want = result_q.pop_front();
                if (out_data.byte_role !== want.byte_role)
                begin
                    $display("%0t: byte_role expected %0d actual %0d",
                             $time, want.byte_role, out_data.byte_role);
                    n_errors++;
                end
                if (out_data.value_tag !== want.value_tag)
                begin
                    $display("%0t: value_tag expected %0d actual %0d",
                             $time, want.value_tag, out_data.value_tag);
                    n_errors++;
                end
                if (out_data.nest_depth !== want.nest_depth)
                begin
                    $display("%0t: nest_depth expected %0d actual %0d",
                             $time, want.nest_depth, out_data.nest_depth);
                    n_errors++;
                end
                if (out_data.value_done !== want.value_done)
                begin
                    $display("%0t: value_done expected %0d actual %0d",
                             $time, want.value_done, out_data.value_done);
                    n_errors++;
                end
                if (out_data.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    n_errors++;
                end
                if (out_data.end_of_buffer !== want.end_of_buffer)
                begin
                    $display("%0t: end_of_buffer expected %0d actual %0d",
                             $time, want.end_of_buffer, out_data.end_of_buffer);
                    n_errors++;
                end
            end
        end
    end

    // receiver: random stall, plus a long hold-off counted here on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_cnt = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: too long without a beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else if (in_valid || result_q.size() != 0)
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Driving helpers
    // ---------------------------------------------------------------
    task automatic send_beat(logic [7:0] b, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // send enc_q as one buffer, last byte marked
    task automatic send_buffer();
        for (int i = 0; i < enc_q.size(); i++)
            send_beat(enc_q[i], i == enc_q.size() - 1);
        enc_q.delete();
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        // the block is already idle once every result is taken; this adds margin
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_NODES)
            m_max_nodes = val;
        else if (idx == CFG_MAX_DEPTH)
            m_max_depth = val[6:0];
    endtask

    // append one byte to the buffer being assembled
    task automatic enq_byte(logic [7:0] b);
        enc_q.insert(enc_q.size(), b);
    endtask

    task automatic put_len(logic [31:0] n);
        for (int i = 0; i < 4; i++)
            enq_byte(n[8*i +: 8]);
    endtask

    // one UTF-8 sequence, valid most of the time
    task automatic put_utf8_char(output int nb);
        logic [7:0] lead;
        case ($urandom_range(7))
            0: begin enq_byte(8'($urandom_range(8'h7F))); nb = 1; end
            1:
            begin
                enq_byte(8'($urandom_range(8'hDF, 8'hC2)));
                enq_byte(8'($urandom_range(8'hBF, 8'h80)));
                nb = 2;
            end
            2:
            begin
                lead = 8'($urandom_range(8'hEF, 8'hE0));
                enq_byte(lead);
                if (lead == 8'hE0)
                    enq_byte(8'($urandom_range(8'hBF, 8'hA0)));
                else if (lead == 8'hED)
                    enq_byte(8'($urandom_range(8'h9F, 8'h80)));
                else
                    enq_byte(8'($urandom_range(8'hBF, 8'h80)));
                enq_byte(8'($urandom_range(8'hBF, 8'h80)));
                nb = 3;
            end
            3:
            begin
                lead = 8'($urandom_range(8'hF4, 8'hF0));
                enq_byte(lead);
                if (lead == 8'hF0)
                    enq_byte(8'($urandom_range(8'hBF, 8'h90)));
                else if (lead == 8'hF4)
                    enq_byte(8'($urandom_range(8'h8F, 8'h80)));
                else
                    enq_byte(8'($urandom_range(8'hBF, 8'h80)));
                enq_byte(8'($urandom_range(8'hBF, 8'h80)));
                enq_byte(8'($urandom_range(8'hBF, 8'h80)));
                nb = 4;
            end
            4: begin enq_byte(8'($urandom_range(255))); nb = 1; end
            default: begin enq_byte(8'($urandom_range(8'h7E, 8'h20))); nb = 1; end
        endcase
    endtask

    // random value, well-formed but for an odd bad UTF-8 byte; lists open only below level 4
    task automatic put_value(int lvl);
        int pick;
        int n;
        int nb;
        int at;
        pick = $urandom_range(9);
        if (pick == 9 && lvl < 4)
        begin
            n = $urandom_range(3);
            enq_byte(TAG_LIST);
            put_len(n);
            for (int i = 0; i < n; i++)
                put_value(lvl + 1);
        end
        else if (pick <= 2)
            enq_byte(pick[7:0]);
        else if (pick <= 4)
        begin
            enq_byte(TAG_INT);
            repeat (8) enq_byte(8'($urandom_range(255)));
        end
        else if (pick <= 6)
        begin
            enq_byte(TAG_STR);
            at = enc_q.size();
            put_len(0);
            n = 0;
            repeat ($urandom_range(4))
            begin
                put_utf8_char(nb);
                n += nb;
            end
            for (int i = 0; i < 4; i++)
                enc_q[at + i] = n[8*i +: 8];
        end
        else
        begin
            enq_byte(TAG_RAW);
            n = $urandom_range(6);
            put_len(n);
            repeat (n) enq_byte(8'($urandom_range(255)));
        end
    endtask

    // nested chain of single-element lists around a null
    task automatic put_chain(int levels);
        repeat (levels)
        begin
            enq_byte(TAG_LIST);
            put_len(1);
        end
        enq_byte(TAG_NULL);
    endtask

    task automatic random_buffers(int n_bytes);
        int target;
        int cut;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            put_value(0);
            case ($urandom_range(9))
                0: // truncated
                begin
                    cut = $urandom_range(enc_q.size() - 1, 1);
                    while (enc_q.size() > cut)
                        void'(enc_q.pop_back());
                end
                1: // trailing junk
                    repeat ($urandom_range(3, 1)) enq_byte(8'($urandom_range(255)));
                2: // one byte corrupted
                    enc_q[$urandom_range(enc_q.size() - 1)] = 8'($urandom_range(255));
                default: ;
            endcase
            send_buffer();
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        int nb;
        enc_q = '{TAG_NULL};                               send_buffer();
        enc_q = '{TAG_FALSE};                              send_buffer();
        enc_q = '{TAG_TRUE, 8'hFF};                        send_buffer(); // trailing
        enc_q = '{8'hFF};                                  send_buffer(); // bad tag
        enc_q = '{8'h07, 8'h00};                           send_buffer();
        enc_q = '{TAG_INT, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
        send_buffer();
        enc_q = '{TAG_INT, 8'h12};                         send_buffer(); // truncated
        // string "A" then a good 4-byte sequence
        enc_q = '{TAG_STR, 8'h05, 8'h00, 8'h00, 8'h00, 8'h41, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_buffer();
        // overlong, surrogate, open sequence at end of payload
        enc_q = '{TAG_STR, 8'h02, 8'h00, 8'h00, 8'h00, 8'hC0, 8'h80}; send_buffer();
        enc_q = '{TAG_STR, 8'h03, 8'h00, 8'h00, 8'h00, 8'hED, 8'hA0, 8'h80}; send_buffer();
        enc_q = '{TAG_STR, 8'h01, 8'h00, 8'h00, 8'h00, 8'hE2}; send_buffer();
        // bad UTF-8 in a truncated buffer still reports truncation
        enc_q = '{TAG_STR, 8'h04, 8'h00, 8'h00, 8'h00, 8'hFF}; send_buffer();
        enc_q = '{TAG_RAW, 8'h00, 8'h00, 8'h00, 8'h00};    send_buffer();
        enc_q = '{TAG_RAW, 8'h02, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00}; send_buffer();
        // empty list, list of two, list count beyond the buffer
        enc_q = '{TAG_LIST, 8'h00, 8'h00, 8'h00, 8'h00};   send_buffer();
        enc_q = '{TAG_LIST, 8'h02, 8'h00, 8'h00, 8'h00, TAG_NULL, TAG_TRUE}; send_buffer();
        enc_q = '{TAG_LIST, 8'hFF, 8'hFF, 8'h00, 8'h00, TAG_NULL}; send_buffer();
        // list count above the node budget
        enc_q = '{TAG_LIST, 8'hFF, 8'hFF, 8'hFF, 8'hFF};   send_buffer();
        // four random one-character strings, each lead byte class picked at random
        repeat (4)
        begin
            enc_q = '{TAG_STR, 8'h00, 8'h00, 8'h00, 8'h00};
            put_utf8_char(nb);
            enc_q[1] = nb[7:0];
            send_buffer();
        end
    endtask

    task automatic test_limits();
        write_reg(CFG_MAX_DEPTH, 32'd1);
        put_chain(1); send_buffer();
        put_chain(2); send_buffer();
        write_reg(CFG_MAX_DEPTH, 32'd0); // refuses every list
        put_chain(1); send_buffer();
        // a chain one list deeper than the stack allows, clipped by the stack size
        write_reg(CFG_MAX_DEPTH, 32'h7F);
        put_chain(STACK_DEPTH + 1); send_buffer();
        write_reg(CFG_MAX_NODES, 32'd1);
        put_chain(0); send_buffer();
        put_chain(1); send_buffer();
        enc_q = '{TAG_LIST, 8'h00, 8'h00, 8'h00, 8'h00}; send_buffer();
        write_reg(CFG_MAX_NODES, 32'd3);
        // tag arriving with the budget spent
        enc_q = '{TAG_LIST, 8'h02, 8'h00, 8'h00, 8'h00, TAG_LIST, 8'h01, 8'h00, 8'h00, 8'h00,
                  TAG_NULL, TAG_NULL};
        send_buffer();
        random_buffers(20);
        write_reg(CFG_MAX_NODES, 32'hFFFF_FFFF);
        enc_q = '{TAG_LIST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, TAG_NULL}; send_buffer();
        write_reg(CFG_SPARE_A, 32'd0);
        write_reg(CFG_SPARE_B, 32'd0);
        put_chain(3); send_buffer();
        write_reg(CFG_MAX_NODES, 32'd6);
        write_reg(CFG_MAX_DEPTH, 32'd3);
        random_buffers(30);
        write_reg(CFG_MAX_NODES, 32'd65536);
        write_reg(CFG_MAX_DEPTH, 32'd64);
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  random_buffers(100);
        send_idle_pct = 45; recv_stall_pct = 0;  random_buffers(100);
        send_idle_pct = 0;  recv_stall_pct = 45; random_buffers(100);
        send_idle_pct = 23; recv_stall_pct = 23; random_buffers(100);
    endtask

    // receiver holds off while the sender keeps offering, filling the block
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 10;
        hold_req = 1'b1;
        random_buffers(40);
        put_chain(12); send_buffer();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        n_errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        bytes_sent = 0;
        m_max_nodes = 32'd65536;
        m_max_depth = 7'd64;
        clear_stream();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limits();
        test_random_phases();
        test_backpressure();

        wait_idle();
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- tagged_value_stream_checker_core.f -----
+incdir+hdl
hdl/tvsc_pkg.sv
hdl/tvsc_ctrl.sv
hdl/tvsc_datapath.sv
hdl/tagged_value_stream_checker_core.sv
bench/tb_tagged_value_stream_checker_core.sv
